FILE: src/tbg_pkg.sv
package tbg_pkg;

  // Field and register widths
  localparam int BPM_W    = 10;
  localparam int SRC_W    = 2;
  localparam int TICK_W   = 10;
  localparam int PERIOD_W = 16;
  localparam int OUT_W    = 21;
  localparam int CFG_W    = 10;
  localparam int CFG_IDX_W = 1;

  // Default width of the beat timer and the carried offset
  localparam int TIMER_BITS_DEF = 20;

  // Tempo constants
  localparam logic [PERIOD_W-1:0] MS_PER_MINUTE = 16'd60000;
  localparam logic [BPM_W-1:0]    BPM_RESET     = 10'd120;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET  = 16'd500;
  localparam int PERIOD_MIN = 60000 / ((1 << BPM_W) - 1);

  // Start offset: late once the truncated percentage left exceeds this
  localparam int PCT_SCALE    = 100;
  localparam int LATE_PERCENT = 25;
  localparam int CMP_W        = PERIOD_W + 7;

  // Lower bound of the time to the next beat
  localparam int TTN_FLOOR = -1048575;

  // Period divider: one quotient bit per step
  localparam int DIV_STEPS = PERIOD_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Beat source codes
  localparam logic [SRC_W-1:0] SRC_NONE = 2'd0;
  localparam logic [SRC_W-1:0] SRC_INT  = 2'd1;
  localparam logic [SRC_W-1:0] SRC_EXT  = 2'd2;

  // Request function codes
  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_BEAT = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_BPM = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SRC = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic take;
    logic div_start;
    logic div_run;
    logic add;
    logic fire;
    logic ttn;
    logic offs;
  } tbg_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic bpm_chg;
    logic div_done;
  } tbg_sts_t;

endpackage

FILE: src/tbg_ifs.sv
interface tbg_in_if;
  logic                        valid;
  logic                        ready;
  logic                        func;
  logic [tbg_pkg::TICK_W-1:0]  tick_ms;

  modport source (output valid, func, tick_ms, input ready);
  modport sink   (input valid, func, tick_ms, output ready);
endinterface

interface tbg_out_if;
  logic                                valid;
  logic                                ready;
  logic                                beat_now;
  logic                                beat_fired;
  logic signed [tbg_pkg::OUT_W-1:0]    time_to_next_ms;
  logic signed [tbg_pkg::OUT_W-1:0]    start_offset_ms;
  logic        [tbg_pkg::PERIOD_W-1:0] period_ms;

  modport source (output valid, beat_now, beat_fired, time_to_next_ms, start_offset_ms,
                  period_ms, input ready);
  modport sink   (input valid, beat_now, beat_fired, time_to_next_ms, start_offset_ms,
                  period_ms, output ready);
endinterface

FILE: src/tbg_ctrl.sv
module tbg_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  tbg_pkg::tbg_sts_t sts,
  output tbg_pkg::tbg_cmd_t cmd
);
  import tbg_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DSTART = 3'd1;
  localparam logic [2:0] ST_DIV    = 3'd2;
  localparam logic [2:0] ST_ADD    = 3'd3;
  localparam logic [2:0] ST_FIRE   = 3'd4;
  localparam logic [2:0] ST_TTN    = 3'd5;
  localparam logic [2:0] ST_OFFS   = 3'd6;
  localparam logic [2:0] ST_SEND   = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       pend_r, pend_nxt;

  // Sequence one request or one period recompute
  always_comb begin
    state_nxt = state_r;
    pend_nxt  = pend_r | sts.bpm_chg;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (pend_r) begin
          state_nxt = ST_DSTART;
          pend_nxt  = sts.bpm_chg;
        end else if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = ST_ADD;
        end
      end
      ST_DSTART: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_run = 1'b1;
        if (sts.div_done) state_nxt = ST_IDLE;
      end
      ST_ADD: begin
        cmd.add   = 1'b1;
        state_nxt = ST_FIRE;
      end
      ST_FIRE: begin
        cmd.fire  = 1'b1;
        state_nxt = ST_TTN;
      end
      ST_TTN: begin
        cmd.ttn   = 1'b1;
        state_nxt = ST_OFFS;
      end
      ST_OFFS: begin
        cmd.offs  = 1'b1;
        state_nxt = ST_SEND;
      end
      ST_SEND: begin
        if (out_ready) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE) && !pend_r;
  assign out_valid = (state_r == ST_SEND);

  // One request in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("request taken while a result waits");

  // Result is presented once the add, fire, time-to-next and offset states have run
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> ##5 out_valid)
    else $error("result not presented on time");

endmodule

FILE: src/tbg_dp.sv
module tbg_dp #(
  parameter int TIMER_BITS = tbg_pkg::TIMER_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [tbg_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [tbg_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic                               in_func,
  input  logic [tbg_pkg::TICK_W-1:0]         in_tick_ms,
  input  tbg_pkg::tbg_cmd_t                  cmd,
  output tbg_pkg::tbg_sts_t                  sts,
  output logic                               out_beat_now,
  output logic                               out_beat_fired,
  output logic signed [tbg_pkg::OUT_W-1:0]   out_time_to_next_ms,
  output logic signed [tbg_pkg::OUT_W-1:0]   out_start_offset_ms,
  output logic [tbg_pkg::PERIOD_W-1:0]       out_period_ms
);
  import tbg_pkg::*;

  localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};
  localparam int TTN_W = (TIMER_BITS + 2 > OUT_W + 1) ? TIMER_BITS + 2 : OUT_W + 1;
  localparam logic signed [TTN_W-1:0] FLOOR_W = TTN_W'(TTN_FLOOR);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

  // Configuration and beat state
  logic [BPM_W-1:0]      bpm_r;
  logic [SRC_W-1:0]      src_r;
  logic [PERIOD_W-1:0]   period_r, period_nxt;
  logic [TIMER_BITS-1:0] timer_r, timer_nxt;
  logic [TIMER_BITS-1:0] carry_r, carry_nxt;
  logic                  pending_r, pending_nxt;

  // Latched request and per-request flags
  logic                  func_r;
  logic [TICK_W-1:0]     tick_r;
  logic                  now_r, now_nxt;
  logic                  fired_r, fired_nxt;
  logic signed [OUT_W-1:0] ttn_r;

  // Period divider
  logic [BPM_W-1:0]      dvs_r;
  logic [BPM_W-1:0]      rem_r;
  logic [PERIOD_W-1:0]   dq_r;
  logic [DIV_CNT_W-1:0]  cnt_r;
  logic [BPM_W:0]        trial;
  logic                  trial_ge;
  logic [BPM_W:0]        trial_sub;

  logic bpm_chg, src_chg;
  logic [TIMER_BITS:0] sum_add, elapsed, over;
  logic                fire_hit;
  logic [TIMER_BITS-1:0] over_sat;
  logic [TTN_W-1:0]    ttn_diff;
  logic signed [TTN_W-1:0] ttn_full;
  logic [CMP_W-1:0]    pct_lhs, pct_rhs;
  logic                late;

  // Detect register writes that change a value
  assign bpm_chg = cfg_we && (cfg_idx == CFG_IDX_BPM) && (cfg_wdata[BPM_W-1:0] != bpm_r);
  assign src_chg = cfg_we && (cfg_idx == CFG_IDX_SRC) && (cfg_wdata[SRC_W-1:0] != src_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpm_r <= BPM_RESET;
      src_r <= SRC_NONE;
    end else begin
      if (bpm_chg) bpm_r <= cfg_wdata[BPM_W-1:0];
      if (src_chg) src_r <= cfg_wdata[SRC_W-1:0];
    end
  end

  // Restoring divide of one minute by bpm, one quotient bit per step
  assign trial     = {rem_r, dq_r[PERIOD_W-1]};
  assign trial_ge  = trial >= {1'b0, dvs_r};
  assign trial_sub = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dvs_r <= (bpm_r == '0) ? BPM_W'(1) : bpm_r;
      rem_r <= '0;
      dq_r  <= MS_PER_MINUTE;
      cnt_r <= '0;
    end else if (cmd.div_run) begin
      rem_r <= trial_ge ? trial_sub[BPM_W-1:0] : trial[BPM_W-1:0];
      dq_r  <= {dq_r[PERIOD_W-2:0], trial_ge};
      cnt_r <= cnt_r + DIV_CNT_W'(1);
    end
  end

  assign sts.div_done = (cnt_r == DIV_LAST);
  assign sts.bpm_chg  = bpm_chg;

  always_comb begin
    period_nxt = period_r;
    if (cmd.div_run && (cnt_r == DIV_LAST)) period_nxt = {dq_r[PERIOD_W-2:0], trial_ge};
  end

  // Latch the request
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      func_r <= in_func;
      tick_r <= in_tick_ms;
    end
  end

  // Advance the timer, check the beat, carry the overshoot
  assign sum_add  = {1'b0, timer_r} + (TIMER_BITS+1)'(tick_r);
  assign elapsed  = {1'b0, timer_r} + {1'b0, carry_r};
  assign fire_hit = (src_r == SRC_INT) && (elapsed >= (TIMER_BITS+1)'(period_r));
  assign over     = elapsed - (TIMER_BITS+1)'(period_r);
  assign over_sat = over[TIMER_BITS] ? TMAX : over[TIMER_BITS-1:0];

  always_comb begin
    timer_nxt   = timer_r;
    carry_nxt   = carry_r;
    pending_nxt = pending_r;
    now_nxt     = now_r;
    fired_nxt   = fired_r;
    if (bpm_chg || src_chg) begin
      timer_nxt = '0;
    end else if (cmd.add) begin
      if (func_r == FUNC_TICK) timer_nxt = sum_add[TIMER_BITS] ? TMAX : sum_add[TIMER_BITS-1:0];
    end else if (cmd.fire) begin
      fired_nxt = 1'b0;
      if (func_r == FUNC_BEAT) begin
        pending_nxt = 1'b1;
        now_nxt     = 1'b0;
      end else begin
        pending_nxt = 1'b0;
        if (fire_hit) begin
          carry_nxt = over_sat;
          timer_nxt = '0;
          fired_nxt = 1'b1;
          now_nxt   = 1'b1;
        end else if (src_r == SRC_INT || src_r == SRC_EXT) begin
          now_nxt = pending_r;
        end else begin
          now_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r  <= PERIOD_RESET;
      timer_r   <= '0;
      carry_r   <= '0;
      pending_r <= 1'b0;
    end else begin
      period_r  <= period_nxt;
      timer_r   <= timer_nxt;
      carry_r   <= carry_nxt;
      pending_r <= pending_nxt;
    end
  end

  always_ff @(posedge clk) begin
    now_r   <= now_nxt;
    fired_r <= fired_nxt;
  end

  // Time to next beat, floored
  assign ttn_diff = TTN_W'(period_r) - TTN_W'(timer_r);
  assign ttn_full = signed'(ttn_diff);

  always_ff @(posedge clk) begin
    if (cmd.ttn) ttn_r <= (ttn_full < FLOOR_W) ? FLOOR_W[OUT_W-1:0] : ttn_full[OUT_W-1:0];
  end

  // Late once the whole percentage left is above the threshold
  assign pct_lhs = CMP_W'(ttn_r[PERIOD_W-1:0]) * CMP_W'(PCT_SCALE);
  assign pct_rhs = CMP_W'(period_r) * CMP_W'(LATE_PERCENT + 1);
  assign late    = !ttn_r[OUT_W-1] && (pct_lhs >= pct_rhs);

  // Load the result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_beat_now   <= 1'b0;
      out_beat_fired <= 1'b0;
    end else if (cmd.offs) begin
      out_beat_now   <= now_r;
      out_beat_fired <= fired_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.offs) begin
      out_time_to_next_ms <= ttn_r;
      out_start_offset_ms <= late ? -ttn_r : ttn_r;
      out_period_ms       <= period_r;
    end
  end

  a_period_range: assert property (@(posedge clk) disable iff (!rst_n)
    period_r >= PERIOD_W'(PERIOD_MIN))
    else $error("beat period below the fastest tempo");

  a_fired_is_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_beat_fired |-> out_beat_now)
    else $error("fired beat not reported as active");

  a_fire_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.fire && (func_r == FUNC_TICK) && fire_hit) |=> (timer_r == '0))
    else $error("timer not restarted after a beat");

endmodule

FILE: src/tempo_beat_generator_top.sv
// A result is presented once the controller has walked the add, fire,
// time-to-next and offset steps for its request. A new request is taken
// only after the result side has taken the last result.
// A tempo change recomputes the period in a bit-serial divider,
// during which no request is taken. Reset (synchronous, rst_n low) restores
// 120 bpm, source none, period 500 ms, timer, carry and pending beat cleared.
module tempo_beat_generator_top #(
  parameter int TIMER_BITS = tbg_pkg::TIMER_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  tbg_in_if.sink                        in_ch,
  tbg_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [tbg_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [tbg_pkg::CFG_W-1:0]     cfg_wdata
);
  import tbg_pkg::*;

  tbg_cmd_t cmd;
  tbg_sts_t sts;

  tbg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tbg_dp #(
    .TIMER_BITS (TIMER_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_idx             (cfg_idx),
    .cfg_wdata           (cfg_wdata),
    .in_func             (in_ch.func),
    .in_tick_ms          (in_ch.tick_ms),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_beat_now        (out_ch.beat_now),
    .out_beat_fired      (out_ch.beat_fired),
    .out_time_to_next_ms (out_ch.time_to_next_ms),
    .out_start_offset_ms (out_ch.start_offset_ms),
    .out_period_ms       (out_ch.period_ms)
  );

endmodule

FILE: dv/testbench.sv
module testbench;
  import tbg_pkg::*;

  localparam int TIMER_BITS    = TIMER_BITS_DEF;
  localparam int HOLD_CYCLES   = 300;
  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_ITEMS   = 305;
  localparam int RETUNE_EVERY  = 60;
  localparam int PRINT_CAP     = 40;

  // Spare source code, handled like none
  localparam logic [SRC_W-1:0] SRC_SPARE = 2'd3;

  // Tempo tracker: mirrors the timer, carry and pending beat, queues expected results
  class beat_tracker #(int TB = TIMER_BITS_DEF);
    typedef struct packed {
      logic                       beat_now;
      logic                       beat_fired;
      logic signed [OUT_W-1:0]    ttn;
      logic signed [OUT_W-1:0]    offs;
      logic        [PERIOD_W-1:0] period;
    } beat_result_t;

    logic [BPM_W-1:0] bpm;
    logic [SRC_W-1:0] src;
    longint           timer_ms;
    longint           carry_ms;
    bit               pending;
    longint           period_ms;
    beat_result_t     expected_beats[$];
    int               mismatches;
    int               requests;
    int               reg_writes;
    int               beats_seen;

    function new();
      bpm        = BPM_RESET;
      src        = SRC_NONE;
      timer_ms   = 0;
      carry_ms   = 0;
      pending    = 1'b0;
      period_ms  = PERIOD_RESET;
      mismatches = 0;
      requests   = 0;
      reg_writes = 0;
      beats_seen = 0;
    endfunction

    function longint timer_cap();
      return (longint'(1) << TB) - 1;
    endfunction

    // Zero bpm counts as one beat per minute
    function longint period_for(logic [BPM_W-1:0] b);
      longint d;
      d = (b == '0) ? 1 : longint'(b);
      return longint'(MS_PER_MINUTE) / d;
    endfunction

    // Build a result from the current timer and period
    function beat_result_t beat_report(logic now, logic fired);
      beat_result_t r;
      longint ttn;
      longint pct;
      longint offs;
      ttn = period_ms - timer_ms;
      if (ttn < TTN_FLOOR) ttn = TTN_FLOOR;
      pct  = (PCT_SCALE * ttn) / period_ms;
      offs = (pct <= LATE_PERCENT) ? ttn : -ttn;
      r.beat_now   = now;
      r.beat_fired = fired;
      r.ttn        = ttn[OUT_W-1:0];
      r.offs       = offs[OUT_W-1:0];
      r.period     = period_ms[PERIOD_W-1:0];
      return r;
    endfunction

    // A new value restarts the timer; the carry survives
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      reg_writes++;
      if (idx == CFG_IDX_BPM) begin
        if (data[BPM_W-1:0] != bpm) begin
          bpm       = data[BPM_W-1:0];
          period_ms = period_for(bpm);
          timer_ms  = 0;
        end
      end else begin
        if (data[SRC_W-1:0] != src) begin
          period_ms = period_for(bpm);
          timer_ms  = 0;
          src       = data[SRC_W-1:0];
        end
      end
    endfunction

    function void note_request(logic func, logic [TICK_W-1:0] tick);
      bit     fired;
      longint elapsed;
      fired = 1'b0;
      requests++;
      // Beat request: arm for the next tick, report unchanged state
      if (func == FUNC_BEAT) begin
        pending = 1'b1;
        expected_beats.push_back(beat_report(1'b0, 1'b0));
        return;
      end
      timer_ms += tick;
      if (timer_ms > timer_cap()) timer_ms = timer_cap();
      if (src == SRC_INT) begin
        elapsed = timer_ms + carry_ms;
        if (elapsed >= period_ms) begin
          carry_ms = elapsed - period_ms;
          if (carry_ms > timer_cap()) carry_ms = timer_cap();
          pending  = 1'b1;
          timer_ms = 0;
          fired    = 1'b1;
        end
      end else if (src != SRC_EXT) begin
        pending = 1'b0;
      end
      expected_beats.push_back(beat_report(pending, fired));
      pending = 1'b0;
    endfunction

    task flag_mismatch(string what, longint got, longint want);
      if (mismatches < PRINT_CAP)
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      mismatches++;
    endtask

    task check_result(logic now, logic fired, logic signed [OUT_W-1:0] ttn,
                      logic signed [OUT_W-1:0] offs, logic [PERIOD_W-1:0] period);
      beat_result_t want;
      if (expected_beats.size() == 0) begin
        flag_mismatch("result with no request outstanding", longint'(0), longint'(0));
        return;
      end
      want = expected_beats.pop_front();
      if (fired === 1'b1) beats_seen++;
      if (now !== want.beat_now)
        flag_mismatch("beat_now", longint'(now), longint'(want.beat_now));
      if (fired !== want.beat_fired)
        flag_mismatch("beat_fired", longint'(fired), longint'(want.beat_fired));
      if (ttn !== want.ttn)
        flag_mismatch("time_to_next_ms", longint'(ttn), longint'(want.ttn));
      if (offs !== want.offs)
        flag_mismatch("start_offset_ms", longint'(offs), longint'(want.offs));
      if (period !== want.period)
        flag_mismatch("period_ms", longint'(period), longint'(want.period));
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;

  tbg_in_if  in_ch();
  tbg_out_if out_ch();

  beat_tracker #(TIMER_BITS) sb;

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  bit hold_armed     = 1'b0;
  bit hold_done      = 1'b0;
  int quiet_cycles   = 0;

  tempo_beat_generator_top #(.TIMER_BITS(TIMER_BITS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  // Observe handshakes and register writes at the edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) sb.note_request(in_ch.func, in_ch.tick_ms);
      if (out_ch.valid && out_ch.ready)
        sb.check_result(out_ch.beat_now, out_ch.beat_fired, out_ch.time_to_next_ms,
                        out_ch.start_offset_ms, out_ch.period_ms);
      if (cfg_we) sb.write_reg(cfg_idx, cfg_wdata);
    end
  end

  // Give up when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[%0t] no handshake for %0d cycles", $time, QUIET_LIMIT);
        $display("tempo_beat_generator_top test failed");
        $finish;
      end
    end
  end

  // Result side: random stalls, plus one long hold-off when armed
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_armed && !hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // Offer one request, with random idle cycles ahead of it
  task automatic send_request(input logic f, input logic [TICK_W-1:0] t);
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.func    <= f;
    in_ch.tick_ms <= t;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Drop valid and wait for every outstanding result
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.expected_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    settle();
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [TICK_W-1:0] pick_tick();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return TICK_W'($urandom_range(0, 60));
      3, 4, 5: return TICK_W'($urandom_range(0, 1023));
      default: return TICK_W'($urandom_range(100, 600));
    endcase
  endfunction

  // New tempo and source, extremes weighted in; source writes carry junk upper bits
  task automatic retune();
    logic [CFG_W-1:0] w;
    int roll;
    case ($urandom_range(9))
      0:       w = '0;
      1:       w = '1;
      2:       w = CFG_W'(1);
      3, 4:    w = CFG_W'($urandom_range(1, 1023));
      default: w = CFG_W'($urandom_range(60, 1023));
    endcase
    set_reg(CFG_IDX_BPM, w);
    w    = CFG_W'($urandom());
    roll = $urandom_range(19);
    w[SRC_W-1:0] = (roll < 10) ? SRC_INT : (roll < 14) ? SRC_EXT :
                   (roll < 17) ? SRC_NONE : SRC_SPARE;
    set_reg(CFG_IDX_SRC, w);
  endtask

  task automatic run_phase(input int src_idle, input int sink_stall, input bit with_hold);
    src_idle_pct   = src_idle;
    sink_stall_pct = sink_stall;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if (i % RETUNE_EVERY == 0) retune();
      if (with_hold && i == 80) hold_armed = 1'b1;
      if ($urandom_range(99) < 15) send_request(FUNC_BEAT, TICK_W'($urandom()));
      else send_request(FUNC_TICK, pick_tick());
    end
  endtask

  initial begin
    sb = new();
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.func    <= FUNC_TICK;
    in_ch.tick_ms <= '0;
    cfg_we        <= 1'b0;
    cfg_idx       <= CFG_IDX_BPM;
    cfg_wdata     <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: none mode drops a request, ignored tick field on a request
    send_request(FUNC_BEAT, '1);
    send_request(FUNC_TICK, '0);
    // Internal: overshoot carried twice, then a pending request reported
    set_reg(CFG_IDX_SRC, CFG_W'(SRC_INT));
    send_request(FUNC_TICK, '1);
    send_request(FUNC_TICK, '0);
    send_request(FUNC_TICK, TICK_W'(400));
    send_request(FUNC_BEAT, '0);
    send_request(FUNC_TICK, TICK_W'(1));
    // External: percentage just over and at the late limit, then overdue
    set_reg(CFG_IDX_SRC, CFG_W'(SRC_EXT));
    send_request(FUNC_TICK, TICK_W'(370));
    send_request(FUNC_TICK, TICK_W'(5));
    send_request(FUNC_TICK, TICK_W'(700));
    send_request(FUNC_BEAT, '0);
    send_request(FUNC_TICK, '0);
    // Spare source code drops the request
    set_reg(CFG_IDX_SRC, CFG_W'(SRC_SPARE));
    send_request(FUNC_BEAT, '0);
    send_request(FUNC_TICK, TICK_W'(5));
    // Zero and top tempo, then rewrites of held values
    set_reg(CFG_IDX_BPM, '0);
    set_reg(CFG_IDX_SRC, CFG_W'(SRC_INT));
    send_request(FUNC_TICK, TICK_W'(1000));
    set_reg(CFG_IDX_BPM, '1);
    send_request(FUNC_TICK, '1);
    set_reg(CFG_IDX_BPM, CFG_W'(1));
    send_request(FUNC_TICK, TICK_W'(300));
    set_reg(CFG_IDX_BPM, CFG_W'(1));
    set_reg(CFG_IDX_SRC, CFG_W'(SRC_INT));
    send_request(FUNC_TICK, TICK_W'(300));

    // Random phases under different idle and stall mixes
    run_phase(0, 0, 1'b1);
    run_phase(45, 0, 1'b0);
    run_phase(0, 45, 1'b0);
    run_phase(16, 16, 1'b0);

    settle();
    $display("covered %0d requests and %0d register writes, %0d beats fired by the generator",
             sb.requests, sb.reg_writes, sb.beats_seen);
    $display("including a long result-side hold-off and random tempo and source changes");
    if (sb.mismatches == 0) begin
      $display("tempo_beat_generator_top test passed");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("tempo_beat_generator_top test failed");
    end
    $finish;
  end

endmodule
